[rtl/bsmh_pkg.sv]
// ----------------------------------------------------------------------------
// bsmh_pkg: shared types and constants for the byte stream mix hash
// Holds the three-word state type, the pipeline job tags, the start
// values and the single-round mix function used by every pipeline stage.
// ----------------------------------------------------------------------------
package bsmh_pkg;

    localparam logic [31:0] GOLDEN_INIT = 32'h9e37_79b9;
    localparam logic [31:0] C_INIT      = 32'h9b97_73e9;

    localparam int BLOCK_BYTES = 12;
    localparam int POS_W       = 4;
    localparam int MIX_STAGES  = 9;
    localparam int ROW_W       = 4;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } words_t;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_BLOCK,
        JOB_FINAL
    } job_kind_t;

    // One round of the three-word mix: subtract the other two words from
    // the target word, then fold in a shifted copy of the last operand.
    function automatic words_t mix_row(input logic [ROW_W-1:0] row, input words_t w);
        words_t      r;
        logic [31:0] d;
        begin
            r = w;
            d = '0;
            case (row)
                4'd0:
                begin
                    d   = w.a - w.b - w.c;
                    r.a = d ^ (w.c >> 13);
                end
                4'd1:
                begin
                    d   = w.b - w.c - w.a;
                    r.b = d ^ (w.a << 8);
                end
                4'd2:
                begin
                    d   = w.c - w.a - w.b;
                    r.c = d ^ (w.b >> 13);
                end
                4'd3:
                begin
                    d   = w.a - w.b - w.c;
                    r.a = d ^ (w.c >> 12);
                end
                4'd4:
                begin
                    d   = w.b - w.c - w.a;
                    r.b = d ^ (w.a << 16);
                end
                4'd5:
                begin
                    d   = w.c - w.a - w.b;
                    r.c = d ^ (w.b >> 5);
                end
                4'd6:
                begin
                    d   = w.a - w.b - w.c;
                    r.a = d ^ (w.c >> 3);
                end
                4'd7:
                begin
                    d   = w.b - w.c - w.a;
                    r.b = d ^ (w.a << 10);
                end
                4'd8:
                begin
                    d   = w.c - w.a - w.b;
                    r.c = d ^ (w.b >> 15);
                end
                default:
                begin
                    r = w;
                end
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/byte_stream_mix_hash.sv]
// ----------------------------------------------------------------------------
// byte_stream_mix_hash: streaming lookup2-style key hash
// Gathers key bytes into twelve-byte groups, mixes each group into three
// words through a nine-stage mix pipeline and emits {a, c} per key.
// ----------------------------------------------------------------------------
// The block takes at most one key byte per request, one request per clock
// cycle when not stalled. Every twelfth byte adds a completed group
// little-endian into words a, b and c and launches the three-word mix, which
// runs as a nine-stage pipeline with one mixing round per stage. The request
// marked last adds the key length and the remaining tail bytes (tail bytes
// for c shifted up one byte) and sends the words through the pipeline once
// more; the hash is loaded into the output register as it leaves the last
// stage, upper word a, lower word c. A request with no byte and last set
// closes the key, even an empty one. The input stalls only in two places:
// while a finished hash waits at the pipeline exit behind a stalled output,
// and when a key ends on a full group or before its last full group has
// reached the last mix stage - the final pass then waits for that group.
// ----------------------------------------------------------------------------
module byte_stream_mix_hash
    import bsmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash_value
);

    localparam int LAST_STAGE = MIX_STAGES - 1;

    // Key state
    words_t                 state_reg;
    words_t                 state_next;
    logic [7:0]             bytes_reg [BLOCK_BYTES];
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [31:0]            len_reg;
    logic [31:0]            len_next;

    // Final pass parked behind a group still in the mix pipeline
    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    words_t                 pend_reg;

    // Mix pipeline
    words_t                 stage_reg [MIX_STAGES];
    job_kind_t              kind_reg  [MIX_STAGES];
    words_t                 stage0_next;
    job_kind_t              kind0_next;
    words_t                 exit_words;

    // Output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [63:0]            hash_reg;

    logic                   advance;
    logic                   accept;
    logic                   block_now;
    logic                   busy_early;
    logic                   exit_block;
    logic                   exit_final;
    logic                   reinject;
    logic                   need_pend;
    logic [POS_W-1:0]       tail_count;
    logic [7:0]             merged   [BLOCK_BYTES];
    logic [7:0]             masked   [BLOCK_BYTES];
    words_t                 cur_words;
    words_t                 block_words;
    words_t                 tail_words;

    // ------------------------------------------------------------------
    // Pipeline exit and flow control
    // ------------------------------------------------------------------
    assign exit_words = mix_row(ROW_W'(LAST_STAGE), stage_reg[LAST_STAGE]);
    assign exit_block = (kind_reg[LAST_STAGE] == JOB_BLOCK);
    assign exit_final = (kind_reg[LAST_STAGE] == JOB_FINAL);

    // Freeze everything while a finished hash cannot leave the pipeline.
    assign advance  = !(exit_final && out_valid_reg && out_stall);
    assign in_stall = !advance || pend_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign reinject = advance && exit_block && pend_valid_reg;

    // A group anywhere before the last stage still owns the key words.
    always_comb
    begin
        busy_early = 1'b0;
        for (int i = 0; i < LAST_STAGE; i++)
        begin
            busy_early = busy_early || (kind_reg[i] == JOB_BLOCK);
        end
    end

    // ------------------------------------------------------------------
    // Byte gathering: merge the incoming byte into the current group
    // ------------------------------------------------------------------
    assign block_now  = has_byte && (pos_reg == POS_W'(BLOCK_BYTES - 1));
    assign tail_count = block_now ? '0 : (pos_reg + POS_W'(has_byte));
    assign len_next   = len_reg + 32'(has_byte);

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            merged[i] = (has_byte && (pos_reg == POS_W'(i))) ? data_byte : bytes_reg[i];
            // Drop bytes left over from an earlier group.
            masked[i] = (POS_W'(i) < tail_count) ? merged[i] : 8'h00;
        end
    end

    assign block_words.a = {merged[3],  merged[2],  merged[1], merged[0]};
    assign block_words.b = {merged[7],  merged[6],  merged[5], merged[4]};
    assign block_words.c = {merged[11], merged[10], merged[9], merged[8]};

    // Tail bytes for c move up one byte; the key length goes in as well.
    assign tail_words.a = {masked[3], masked[2], masked[1], masked[0]};
    assign tail_words.b = {masked[7], masked[6], masked[5], masked[4]};
    assign tail_words.c = {masked[10], masked[9], masked[8], 8'h00} + len_next;

    // Take the group leaving the pipeline this cycle as the key words.
    assign cur_words = (exit_block && !pend_valid_reg) ? exit_words : state_reg;

    assign need_pend = last && (busy_early || block_now);

    // ------------------------------------------------------------------
    // Pipeline entry
    // ------------------------------------------------------------------
    always_comb
    begin
        stage0_next = cur_words;
        kind0_next  = JOB_NONE;
        if (reinject)
        begin
            stage0_next.a = exit_words.a + pend_reg.a;
            stage0_next.b = exit_words.b + pend_reg.b;
            stage0_next.c = exit_words.c + pend_reg.c;
            kind0_next    = JOB_FINAL;
        end
        else if (accept && block_now)
        begin
            stage0_next.a = cur_words.a + block_words.a;
            stage0_next.b = cur_words.b + block_words.b;
            stage0_next.c = cur_words.c + block_words.c;
            kind0_next    = JOB_BLOCK;
        end
        else if (accept && last && !need_pend)
        begin
            stage0_next.a = cur_words.a + tail_words.a;
            stage0_next.b = cur_words.b + tail_words.b;
            stage0_next.c = cur_words.c + tail_words.c;
            kind0_next    = JOB_FINAL;
        end
    end

    // ------------------------------------------------------------------
    // Key state update
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        if (advance && exit_block && !pend_valid_reg)
        begin
            state_next = exit_words;
        end
        if (reinject)
        begin
            pend_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (last)
            begin
                state_next.a    = GOLDEN_INIT;
                state_next.b    = GOLDEN_INIT;
                state_next.c    = C_INIT;
                pos_next        = '0;
                pend_valid_next = need_pend;
            end
            else
            begin
                pos_next = tail_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.a    <= GOLDEN_INIT;
            state_reg.b    <= GOLDEN_INIT;
            state_reg.c    <= C_INIT;
            pos_reg        <= '0;
            len_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            if (accept)
            begin
                len_reg <= last ? 32'h0 : len_next;
            end
        end
    end

    // Group bytes and the parked tail carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept && has_byte)
        begin
            bytes_reg[pos_reg] <= data_byte;
        end
        if (accept && need_pend)
        begin
            pend_reg <= tail_words;
        end
    end

    // ------------------------------------------------------------------
    // Mix pipeline: one round per stage, all stages advance together
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MIX_STAGES; i++)
            begin
                kind_reg[i] <= JOB_NONE;
            end
        end
        else if (advance)
        begin
            kind_reg[0] <= kind0_next;
            for (int i = 1; i < MIX_STAGES; i++)
            begin
                kind_reg[i] <= kind_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= stage0_next;
            for (int i = 1; i < MIX_STAGES; i++)
            begin
                stage_reg[i] <= mix_row(ROW_W'(i - 1), stage_reg[i-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (advance && exit_final)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && exit_final)
        begin
            hash_reg <= {exit_words.a, exit_words.c};
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

[tb/byte_stream_mix_hash_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stream_mix_hash_checker: hash predictor and scoreboard
// Watches both channels of the hash block, rebuilds every key hash from the
// accepted requests and compares each delivered hash with the oldest one
// still outstanding. Mismatches and unexpected hashes raise error_count.
// ----------------------------------------------------------------------------
module byte_stream_mix_hash_checker
    import bsmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] hash_value,
    output int          error_count,
    output int          pending_hashes
);

    words_t      hash_words;
    logic [7:0]  group_buf [BLOCK_BYTES];
    logic [3:0]  group_fill;
    logic [31:0] key_bytes;
    logic [63:0] expected_hashes [$];

    // Nine-round lookup2 mix over the three words.
    function automatic words_t lookup2_mix(input words_t w);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = w.a;
        b = w.b;
        c = w.c;
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
        return '{a: a, b: b, c: c};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [63:0] want;
        logic [31:0] lane;
        int          idx;
        if (!rst_n)
        begin
            hash_words     = '{a: GOLDEN_INIT, b: GOLDEN_INIT, c: C_INIT};
            group_fill     = '0;
            key_bytes      = '0;
            error_count    = 0;
            expected_hashes.delete();
            pending_hashes = 0;
        end
        else
        begin
            // Compare first: a hash leaving now belongs to an older key.
            if (out_valid && !out_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected hash_value %h, expected none", $time, hash_value);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash_value !== want)
                    begin
                        error_count++;
                        $display("%0t: hash_value mismatch, expected %h, got %h",
                                 $time, want, hash_value);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (has_byte)
                begin
                    group_buf[group_fill] = data_byte;
                    group_fill++;
                    key_bytes++;
                    if (group_fill == BLOCK_BYTES)
                    begin
                        hash_words.a += {group_buf[3], group_buf[2], group_buf[1], group_buf[0]};
                        hash_words.b += {group_buf[7], group_buf[6], group_buf[5], group_buf[4]};
                        hash_words.c += {group_buf[11], group_buf[10], group_buf[9], group_buf[8]};
                        hash_words    = lookup2_mix(hash_words);
                        group_fill    = '0;
                    end
                end
                if (last)
                begin
                    hash_words.c += key_bytes;
                    for (idx = 0; idx < group_fill; idx++)
                    begin
                        lane = {24'b0, group_buf[idx]};
                        if (idx < 4)
                            hash_words.a += lane << (8 * idx);
                        else if (idx < 8)
                            hash_words.b += lane << (8 * (idx - 4));
                        else
                            hash_words.c += lane << (8 * (idx - 8) + 8);
                    end
                    hash_words = lookup2_mix(hash_words);
                    expected_hashes.push_back({hash_words.a, hash_words.c});
                    hash_words = '{a: GOLDEN_INIT, b: GOLDEN_INIT, c: C_INIT};
                    group_fill = '0;
                    key_bytes  = '0;
                end
            end
            pending_hashes = expected_hashes.size();
        end
    end

endmodule

[tb/tb_byte_stream_mix_hash.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_stream_mix_hash: testbench for the streaming key hash block
// Feeds directed and random keys through the block under random sender
// gaps and receiver stalls; the checker beside the block predicts every
// hash and the top gives the verdict once all hashes have drained.
// ----------------------------------------------------------------------------
module tb_byte_stream_mix_hash;

    // Generous bound on the whole run, used by the watchdog.
    localparam int CYCLE_LIMIT  = 200000;
    // Time to let the pipeline run dry, which covers the final pass and a
    // possible hold-off behind a group still in the mix.
    localparam int DRAIN_CYCLES = 32;
    localparam int PHASE_BYTES  = 125;
    localparam int PHASE_KEYS   = 12;

    logic        clk       = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] hash_value;

    int          error_count;
    int          pending_hashes;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycle_count   = 0;
    logic        req_taken     = 1'b0;

    always #2 clk = ~clk;

    byte_stream_mix_hash i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    byte_stream_mix_hash_checker i_hash_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hash_value     (hash_value),
        .error_count    (error_count),
        .pending_hashes (pending_hashes)
    );

    // Latch the input handshake at the edge so the driver can read it
    // at the following falling edge without racing the block.
    always @(posedge clk)
    begin
        req_taken <= in_valid && !in_stall;
    end

    // Receiver: stall the output at random at the rate of the current phase;
    // hold it low while reset is active.
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: drop the run if the hashes never drain.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one request at a falling edge and hold it until it is taken.
    // Insert random idle cycles first; idle payload is scrambled so that
    // the block cannot lean on it.
    task automatic send_request(input logic [7:0] value, input logic with_byte,
                                input logic closes);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'($urandom);
            has_byte  <= 1'($urandom);
            last      <= 1'($urandom);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        has_byte  <= with_byte;
        last      <= closes;
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
    endtask

    initial
    begin
        int   phase;
        int   phase_bytes;
        int   phase_keys;
        int   key_len;
        int   pick;
        int   k;
        logic close_on_byte;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        has_byte  = 1'b0;
        last      = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 55;

        // Close an empty key with a request that carries no byte.
        send_request(8'h00, 1'b0, 1'b1);
        // Take a byte and close the key on the same request.
        send_request(8'h00, 1'b1, 1'b1);
        // Fill a whole group on the closing byte: the tail stays empty.
        for (k = 0; k < 12; k++)
            send_request(8'hFF, 1'b1, k == 11);
        // No byte and not last: the block must ignore it.
        send_request(8'hA5, 1'b0, 1'b0);
        // Nine-byte tail so the top tail byte lands shifted in word c.
        for (k = 0; k < 9; k++)
            send_request(8'(k * 29 + 3), 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);

        // Random keys in three phases: receiver-heavy idling, sender-heavy
        // idling, then no idling at all.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 26 : 0;
            phase_bytes   = 0;
            phase_keys    = 0;
            while (phase_bytes < PHASE_BYTES || phase_keys < PHASE_KEYS)
            begin
                // Mostly short keys; some exact multiples of a group so the
                // close lands right behind a mix, and a few longer keys.
                pick = $urandom_range(99);
                if (pick < 10)
                    key_len = 12 * $urandom_range(1, 2);
                else if (pick < 85)
                    key_len = $urandom_range(0, 16);
                else
                    key_len = $urandom_range(17, 40);
                close_on_byte = (key_len != 0) && ($urandom_range(1) == 1);
                for (k = 0; k < key_len; k++)
                begin
                    if ($urandom_range(99) < 4)
                        send_request(8'($urandom), 1'b0, 1'b0);
                    send_request(8'($urandom), 1'b1, close_on_byte && (k == key_len - 1));
                end
                if (!close_on_byte)
                    send_request(8'($urandom), 1'b0, 1'b1);
                phase_bytes += key_len;
                phase_keys++;
            end
        end

        // Drop valid, wait for every predicted hash, then let the pipeline
        // run dry so that a stray extra hash still gets caught.
        in_valid <= 1'b0;
        while (pending_hashes != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/bsmh_pkg.sv
rtl/byte_stream_mix_hash.sv
tb/byte_stream_mix_hash_checker.sv
tb/tb_byte_stream_mix_hash.sv
